[design/rrcm_pkg.sv]
package rrcm_pkg;

  localparam int CoordBits     = 12;
  localparam int RadiusBitsDef = 8;
  localparam int FracBits      = 8;
  localparam int FracOne       = 256;
  localparam int ChanBits      = 8;
  localparam int CfgIdxBits    = 3;
  localparam int CfgDataBits   = 16;

  localparam int WidthReset  = 64;
  localparam int HeightReset = 64;
  localparam int RadiusReset = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFrameWidth  = 3'd0,
    CfgFrameHeight = 3'd1,
    CfgCornerRad   = 3'd2,
    CfgBgRed       = 3'd3,
    CfgBgGreen     = 3'd4,
    CfgBgBlue      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [ChanBits-1:0] out_red;
    logic [ChanBits-1:0] out_green;
    logic [ChanBits-1:0] out_blue;
    logic                is_transparent;
  } result_t;

  // per-pixel control traveling beside the root chain
  typedef struct packed {
    logic valid;
    logic transp;
    logic ring;
  } side_t;

endpackage

[design/rrcm_root_cell.sv]
module rrcm_root_cell #(
  parameter int ROOT_BITS = rrcm_pkg::RadiusBitsDef + rrcm_pkg::FracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrcm_pkg::side_t        side_i,
  input  logic [2*ROOT_BITS-1:0] rad_i,
  input  logic [ROOT_BITS+1:0]   rem_i,
  input  logic [ROOT_BITS-1:0]   root_i,
  output rrcm_pkg::side_t        side_o,
  output logic [2*ROOT_BITS-1:0] rad_o,
  output logic [ROOT_BITS+1:0]   rem_o,
  output logic [ROOT_BITS-1:0]   root_o
);

  logic [ROOT_BITS+1:0] cur;
  logic [ROOT_BITS+1:0] trial;
  logic                 take;
  logic [ROOT_BITS+1:0] rem_d;
  logic [ROOT_BITS-1:0] root_d;
  logic [2*ROOT_BITS-1:0] rad_d;

  // one root digit per cell
  always_comb begin
    cur    = {rem_i[ROOT_BITS-1:0], rad_i[2*ROOT_BITS-1 -: 2]};
    trial  = {root_i, 2'b01};
    take   = (cur >= trial);
    rem_d  = take ? (cur - trial) : cur;
    root_d = {root_i[ROOT_BITS-2:0], take};
    rad_d  = {rad_i[2*ROOT_BITS-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else begin
      side_o <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= rad_d;
    rem_o  <= rem_d;
    root_o <= root_d;
  end

endmodule

[design/rrcm_front.sv]
module rrcm_front #(
  parameter int RADIUS_BITS = rrcm_pkg::RadiusBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  rrcm_pkg::pixel_t                    pixel_i,
  input  logic [rrcm_pkg::CoordBits-1:0]      frame_width_i,
  input  logic [rrcm_pkg::CoordBits-1:0]      frame_height_i,
  input  logic [RADIUS_BITS-1:0]              corner_radius_i,
  output rrcm_pkg::side_t                     side_o,
  output logic [2*(RADIUS_BITS+rrcm_pkg::FracBits)-1:0] rad_o
);

  localparam int CB  = rrcm_pkg::CoordBits;
  localparam int RB  = RADIUS_BITS;
  localparam int SW  = ((CB > RB) ? CB : RB) + 2;
  localparam int D2W = 2 * SW;

  logic signed [SW-1:0] xs, ys, ws, hs, rs;
  logic signed [SW-1:0] wr, hr;
  logic signed [SW-1:0] cx, cy;
  logic                 corner_d;
  logic signed [SW-1:0] dx_d, dy_d;

  logic                 v1_q, corner1_q;
  logic signed [SW-1:0] dx1_q, dy1_q;

  logic signed [D2W-1:0] sqx_full, sqy_full;
  logic                  v2_q, corner2_q;
  logic [D2W-1:0]        sqx2_q, sqy2_q;

  logic [RB-1:0]   rm1;
  logic [2*RB-1:0] rsq_q, rm1sq_q;

  logic [D2W-1:0]  d2;
  rrcm_pkg::side_t side_d;

  // corner tests, first hit wins
  always_comb begin
    xs = $signed({{(SW-CB){1'b0}}, pixel_i.pixel_x});
    ys = $signed({{(SW-CB){1'b0}}, pixel_i.pixel_y});
    ws = $signed({{(SW-CB){1'b0}}, frame_width_i});
    hs = $signed({{(SW-CB){1'b0}}, frame_height_i});
    rs = $signed({{(SW-RB){1'b0}}, corner_radius_i});
    wr = ws - rs;
    hr = hs - rs;
    corner_d = 1'b1;
    cx = rs;
    cy = rs;
    if (xs < rs && ys < rs) begin
      cx = rs;
      cy = rs;
    end else if (xs >= wr && ys < rs) begin
      cx = wr - SW'(1);
      cy = rs;
    end else if (xs < rs && ys >= hr) begin
      cx = rs;
      cy = hr - SW'(1);
    end else if (xs >= wr && ys >= hr) begin
      cx = wr - SW'(1);
      cy = hr - SW'(1);
    end else begin
      corner_d = 1'b0;
    end
    dx_d = xs - cx;
    dy_d = ys - cy;
  end

  assign sqx_full = dx1_q * dx1_q;
  assign sqy_full = dy1_q * dy1_q;

  assign rm1 = (corner_radius_i == '0) ? RB'(1) : (corner_radius_i - RB'(1));

  always_comb begin
    d2 = sqx2_q + sqy2_q;
    side_d.valid  = v2_q;
    side_d.transp = corner2_q && (d2 > D2W'(rsq_q));
    side_d.ring   = corner2_q && (d2 <= D2W'(rsq_q)) && (d2 > D2W'(rm1sq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      side_o <= '0;
    end else begin
      v1_q   <= accept_i;
      v2_q   <= v1_q;
      side_o <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    corner1_q <= corner_d;
    dx1_q     <= dx_d;
    dy1_q     <= dy_d;
    corner2_q <= corner1_q;
    sqx2_q    <= $unsigned(sqx_full);
    sqy2_q    <= $unsigned(sqy_full);
    rsq_q     <= corner_radius_i * corner_radius_i;
    rm1sq_q   <= rm1 * rm1;
    rad_o     <= {d2[2*RB-1:0], {(2*rrcm_pkg::FracBits){1'b0}}};
  end

endmodule

[design/rounded_rect_corner_mask_top.sv]
// Rounded-rectangle corner mask. One pixel word is taken in every clock while busy stays low
// (it never rises). Its result word shows on result_o with done_o high for one cycle, once
// the pixel has passed the front end, the root chain and the output register, and is taken at
// the edge after that. The depth is set by the fixed-point square root, a chain of RADIUS_BITS
// + 8 cells that each resolve one root bit, behind a three-stage corner and distance front end
// and one output register. Results come out in input order and cannot be held off, so the
// receiver has to take every word in its cycle. Configuration writes are always accepted and
// must only be made while no pixel is in flight.
module rounded_rect_corner_mask_top #(
  parameter int RADIUS_BITS = rrcm_pkg::RadiusBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  rrcm_pkg::pixel_t                    pixel_i,
  output logic                                done_o,
  output rrcm_pkg::result_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rrcm_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [rrcm_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int CB  = rrcm_pkg::CoordBits;
  localparam int RB  = RADIUS_BITS;
  localparam int N   = RB + rrcm_pkg::FracBits;
  localparam int RW  = N + 2;
  localparam int CHB = rrcm_pkg::ChanBits;

  logic [CB-1:0]  frame_width_q, frame_height_q;
  logic [RB-1:0]  corner_radius_q;
  logic [CHB-1:0] bg_red_q, bg_green_q, bg_blue_q;

  rrcm_pkg::side_t      side_w [N+1];
  logic [2*N-1:0]       rad_w  [N+1];
  logic [N+1:0]         rem_w  [N+1];
  logic [N-1:0]         root_w [N+1];

  rrcm_pkg::side_t      last;
  logic [N-1:0]         root_dist;
  logic signed [RW-1:0] diff;
  logic [8:0]           ratio;
  logic [8:0]           inv;
  logic [16:0]          pr_r, pr_g, pr_b;
  rrcm_pkg::result_t    res_d, res_q;
  logic                 done_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= CB'(rrcm_pkg::WidthReset);
      frame_height_q  <= CB'(rrcm_pkg::HeightReset);
      corner_radius_q <= RB'(rrcm_pkg::RadiusReset);
      bg_red_q        <= '0;
      bg_green_q      <= '0;
      bg_blue_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rrcm_pkg::cfg_reg_e'(cfg_index_i))
        rrcm_pkg::CfgFrameWidth:  frame_width_q   <= cfg_data_i[CB-1:0];
        rrcm_pkg::CfgFrameHeight: frame_height_q  <= cfg_data_i[CB-1:0];
        rrcm_pkg::CfgCornerRad:   corner_radius_q <= cfg_data_i[RB-1:0];
        rrcm_pkg::CfgBgRed:       bg_red_q        <= cfg_data_i[CHB-1:0];
        rrcm_pkg::CfgBgGreen:     bg_green_q      <= cfg_data_i[CHB-1:0];
        rrcm_pkg::CfgBgBlue:      bg_blue_q       <= cfg_data_i[CHB-1:0];
        default: ;
      endcase
    end
  end

  rrcm_front #(
    .RADIUS_BITS(RB)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (start && !busy),
    .pixel_i        (pixel_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .corner_radius_i(corner_radius_q),
    .side_o         (side_w[0]),
    .rad_o          (rad_w[0])
  );

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rrcm_root_cell #(
      .ROOT_BITS(N)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .side_i(side_w[i]),
      .rad_i (rad_w[i]),
      .rem_i (rem_w[i]),
      .root_i(root_w[i]),
      .side_o(side_w[i+1]),
      .rad_o (rad_w[i+1]),
      .rem_o (rem_w[i+1]),
      .root_o(root_w[i+1])
    );
  end

  assign last      = side_w[N];
  assign root_dist = root_w[N];

  // result word: transparent, edge ring shading or plain background
  always_comb begin
    diff = $signed({2'b00, root_dist}) - $signed({2'b00, corner_radius_q, 8'b0})
         + $signed(RW'(rrcm_pkg::FracOne));
    if (diff < 0) begin
      ratio = '0;
    end else if (diff > $signed(RW'(rrcm_pkg::FracOne))) begin
      ratio = 9'(rrcm_pkg::FracOne);
    end else begin
      ratio = diff[8:0];
    end
    inv  = 9'(rrcm_pkg::FracOne) - ratio;
    pr_r = 17'(bg_red_q) * 17'(inv);
    pr_g = 17'(bg_green_q) * 17'(inv);
    pr_b = 17'(bg_blue_q) * 17'(inv);
    if (last.transp) begin
      res_d.out_red        = '0;
      res_d.out_green      = '0;
      res_d.out_blue       = '0;
      res_d.is_transparent = 1'b1;
    end else if (last.ring) begin
      res_d.out_red        = pr_r[15:8];
      res_d.out_green      = pr_g[15:8];
      res_d.out_blue       = pr_b[15:8];
      res_d.is_transparent = 1'b0;
    end else begin
      res_d.out_red        = bg_red_q;
      res_d.out_green      = bg_green_q;
      res_d.out_blue       = bg_blue_q;
      res_d.is_transparent = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_ring_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid |-> !(last.ring && last.transp))
    else $error("ring and transparent flags both set");

  a_ring_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && last.ring) |->
      (root_dist <= {corner_radius_q, 8'b0}) &&
      (root_dist >= {corner_radius_q - RB'(1), 8'b0}))
    else $error("edge ring root outside the ring");

  a_transp_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && last.transp) |=>
      done_o && result_o.is_transparent && result_o.out_red == '0 &&
      result_o.out_green == '0 && result_o.out_blue == '0)
    else $error("transparent word carries color");
`endif

endmodule

[sim/tb_rounded_rect_corner_mask_top.sv]
module tb_rounded_rect_corner_mask_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrcm_pkg::*;

  localparam int LatencyCycles = 20;
  localparam int StallLimit    = 2000;
  localparam int IdlePercent   = 19;
  localparam int RandomPhases  = 10;
  localparam int PhaseWords    = 150;
  localparam int CoordMax      = (1 << CoordBits) - 1;
  localparam int RadiusMax     = (1 << RadiusBitsDef) - 1;
  localparam int ChanMax       = (1 << ChanBits) - 1;

  localparam logic [CfgIdxBits-1:0] CfgSpareLow  = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHigh = 3'd7;

  typedef struct {
    pixel_t  px;
    result_t want;
  } pixel_expect_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  pixel_t                 pixel_i;
  logic                   done_o;
  result_t                result_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  logic [CoordBits-1:0]     card_width;
  logic [CoordBits-1:0]     card_height;
  logic [RadiusBitsDef-1:0] card_radius;
  logic [ChanBits-1:0]      card_red;
  logic [ChanBits-1:0]      card_green;
  logic [ChanBits-1:0]      card_blue;

  pixel_expect_t expected_colors[$];
  int            mismatches;
  int            stall_cycles;
  bit            idle_enable;

  rounded_rect_corner_mask_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_i     (pixel_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // integer square root, bit by bit from the top
  function automatic longint unsigned fixed_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic logic [ChanBits-1:0] shade(logic [ChanBits-1:0] chan, longint ratio);
    longint v;
    v = (longint'(chan) * (FracOne - ratio)) >>> FracBits;
    return v[ChanBits-1:0];
  endfunction

  function automatic result_t mask_pixel(pixel_t p);
    longint  x, y, w, h, r, cx, cy, dx, dy, d2, ratio;
    bit      in_corner;
    result_t res;
    x = longint'(p.pixel_x);
    y = longint'(p.pixel_y);
    w = longint'(card_width);
    h = longint'(card_height);
    r = longint'(card_radius);
    cx = 0;
    cy = 0;
    in_corner = 1;
    res.out_red = card_red;
    res.out_green = card_green;
    res.out_blue = card_blue;
    res.is_transparent = 1'b0;
    if (x < r && y < r) begin
      cx = r;
      cy = r;
    end else if (x >= w - r && y < r) begin
      cx = w - r - 1;
      cy = r;
    end else if (x < r && y >= h - r) begin
      cx = r;
      cy = h - r - 1;
    end else if (x >= w - r && y >= h - r) begin
      cx = w - r - 1;
      cy = h - r - 1;
    end else begin
      in_corner = 0;
    end
    if (in_corner) begin
      dx = x - cx;
      dy = y - cy;
      d2 = dx * dx + dy * dy;
      if (d2 > r * r) begin
        res = '0;
        res.is_transparent = 1'b1;
      end else if (d2 > (r - 1) * (r - 1)) begin
        // edge ring: fade by the fractional distance past r-1
        ratio = longint'(fixed_root(longint'(d2) <<< (2 * FracBits))) - (r - 1) * FracOne;
        if (ratio < 0) begin
          ratio = 0;
        end
        if (ratio > FracOne) begin
          ratio = FracOne;
        end
        res.out_red = shade(card_red, ratio);
        res.out_green = shade(card_green, ratio);
        res.out_blue = shade(card_blue, ratio);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, pixel_t px, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("pixel (%0d,%0d) %s got %0d want %0d",
                                px.pixel_x, px.pixel_y, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pixel_expect_t head;
    bit            progress;
    if (!rst_ni) begin
      card_width   <= CoordBits'(WidthReset);
      card_height  <= CoordBits'(HeightReset);
      card_radius  <= RadiusBitsDef'(RadiusReset);
      card_red     <= '0;
      card_green   <= '0;
      card_blue    <= '0;
      stall_cycles <= 0;
    end else begin
      progress = 0;
      if (done_o) begin
        progress = 1;
        if (expected_colors.size() == 0) begin
          report_mismatch("result word with no pixel pending");
        end else begin
          head = expected_colors.pop_front();
          compare_field("red", head.px, result_o.out_red, head.want.out_red);
          compare_field("green", head.px, result_o.out_green, head.want.out_green);
          compare_field("blue", head.px, result_o.out_blue, head.want.out_blue);
          compare_field("transparent", head.px, result_o.is_transparent,
                        head.want.is_transparent);
        end
      end
      if (start && !busy) begin
        progress = 1;
        head.px = pixel_i;
        head.want = mask_pixel(pixel_i);
        expected_colors.push_back(head);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1;
        case (cfg_index_i)
          CfgFrameWidth:  card_width  <= cfg_data_i[CoordBits-1:0];
          CfgFrameHeight: card_height <= cfg_data_i[CoordBits-1:0];
          CfgCornerRad:   card_radius <= cfg_data_i[RadiusBitsDef-1:0];
          CfgBgRed:       card_red    <= cfg_data_i[ChanBits-1:0];
          CfgBgGreen:     card_green  <= cfg_data_i[ChanBits-1:0];
          CfgBgBlue:      card_blue   <= cfg_data_i[ChanBits-1:0];
          default: ;
        endcase
      end
      stall_cycles <= progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("** rounded_rect_corner_mask_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_card(int w, int h, int r, int red, int green, int blue);
    write_reg(CfgFrameWidth, {4'($urandom), CoordBits'(w)});
    write_reg(CfgFrameHeight, {4'($urandom), CoordBits'(h)});
    write_reg(CfgCornerRad, {8'($urandom), RadiusBitsDef'(r)});
    write_reg(CfgBgRed, {8'($urandom), ChanBits'(red)});
    write_reg(CfgBgGreen, {8'($urandom), ChanBits'(green)});
    write_reg(CfgBgBlue, {8'($urandom), ChanBits'(blue)});
  endtask

  task automatic send_pixel(int x, int y);
    if (idle_enable) begin
      while ($urandom_range(99) < IdlePercent) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start   <= 1'b1;
    pixel_i <= '{pixel_x: CoordBits'(x), pixel_y: CoordBits'(y)};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_pixel(0, 0);
    send_pixel(5, 5);
    send_pixel(63, 63);
    send_pixel(32, 32);
  endtask

  task automatic test_corner_shapes();
    wait_drained();
    set_card(64, 48, 16, ChanMax, 128, 1);
    send_pixel(0, 0);
    send_pixel(63, 0);
    send_pixel(0, 47);
    send_pixel(63, 47);
    // edge ring points and a point just outside the ring
    send_pixel(5, 5);
    send_pixel(1, 11);
    send_pixel(58, 5);
    send_pixel(5, 42);
    send_pixel(4, 5);
    send_pixel(32, 24);
  endtask

  task automatic test_zero_radius();
    wait_drained();
    set_card(64, 48, 0, 200, 100, 50);
    send_pixel(0, 0);
    send_pixel(63, 47);
    send_pixel(CoordMax, CoordMax);
    send_pixel(CoordMax, 0);
  endtask

  task automatic test_odd_sizes();
    wait_drained();
    set_card(0, 0, RadiusMax, 0, ChanMax, 0);
    send_pixel(0, 0);
    send_pixel(CoordMax, CoordMax);
    send_pixel(200, 10);
    wait_drained();
    // spare register indexes must leave the card alone
    write_reg(CfgSpareLow, '1);
    write_reg(CfgSpareHigh, 16'h1234);
    set_card(CoordMax, CoordMax, RadiusMax, ChanMax, ChanMax, ChanMax);
    send_pixel(CoordMax, CoordMax);
    send_pixel(CoordMax - 75, CoordMax - 75);
    send_pixel(0, CoordMax);
  endtask

  task automatic test_random_cards();
    int w, h, r, x, y, kind;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_drained();
      if (phase == 0) begin
        w = CoordMax;
        h = CoordMax;
        r = RadiusMax;
        set_card(w, h, r, ChanMax, ChanMax, ChanMax);
      end else if (phase == 1) begin
        w = 1;
        h = 1;
        r = 0;
        set_card(w, h, r, 0, 0, 0);
      end else begin
        w = ($urandom_range(3) == 0) ? $urandom_range(1, CoordMax) : $urandom_range(1, 300);
        h = ($urandom_range(3) == 0) ? $urandom_range(1, CoordMax) : $urandom_range(1, 300);
        r = ($urandom_range(7) == 0) ? RadiusMax : $urandom_range(0, 64);
        set_card(w, h, r, $urandom_range(ChanMax), $urandom_range(ChanMax),
                 $urandom_range(ChanMax));
      end
      // a long stretch with no sender gaps
      idle_enable = !(phase == 4 || phase == 5);
      for (int n = 0; n < PhaseWords; n++) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          x = $urandom_range(0, r + 2);
          y = $urandom_range(0, r + 2);
          if ($urandom_range(1)) begin
            x = w - 1 - x;
          end
          if ($urandom_range(1)) begin
            y = h - 1 - y;
          end
        end else if (kind < 85) begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
        end else begin
          x = $urandom_range(0, CoordMax);
          y = $urandom_range(0, CoordMax);
        end
        send_pixel(x, y);
      end
    end
    idle_enable = 1;
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    pixel_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    idle_enable = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_corner_shapes();
    test_zero_radius();
    test_odd_sizes();
    test_random_cards();
    wait_drained();
    repeat (2 * LatencyCycles) @(posedge clk_i);
    if (expected_colors.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", expected_colors.size()));
    end
    if (mismatches == 0) begin
      $display("** rounded_rect_corner_mask_top: PASSED **");
    end else begin
      $display("** rounded_rect_corner_mask_top: FAILED **");
    end
    $finish;
  end

endmodule
